// ----- sv/name_filter_glob_match_macros.svh -----
// Assertion macros shared by the checker of the entry-name filter.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef NAME_FILTER_GLOB_MATCH_MACROS_SVH
`define NAME_FILTER_GLOB_MATCH_MACROS_SVH

// A property that must hold at every sampled edge.
`define NFGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition at one edge that must be followed by another at the next edge.
`define NFGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nfgm_pkg.sv -----
// Types and constants of the entry-name filter.
// Used by the front end, the result queue, the back end and the top level.
`default_nettype none

package nfgm_pkg;

  localparam int unsigned CHAR_BITS   = 16;
  localparam int unsigned PACK_BITS   = 16;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PAT_WORDS   = 6;
  localparam int unsigned LEN_FIELD_W = 5;
  localparam int unsigned ENTRY_W     = 32;

  localparam logic [CHAR_BITS-1:0] STAR_CHAR  = CHAR_BITS'(16'h002A);
  localparam logic [CHAR_BITS-1:0] QMARK_CHAR = CHAR_BITS'(16'h003F);
  localparam logic [CHAR_BITS-1:0] UPPER_A    = CHAR_BITS'(16'h0041);
  localparam logic [CHAR_BITS-1:0] UPPER_Z    = CHAR_BITS'(16'h005A);
  localparam logic [CHAR_BITS-1:0] CASE_SHIFT = CHAR_BITS'(16'h0020);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_MODE,
    REG_PATTERN_LEN,
    REG_PATTERN_A,
    REG_PATTERN_B,
    REG_PATTERN_C,
    REG_PATTERN_D,
    REG_PATTERN_E,
    REG_PATTERN_F
  } cfg_reg_e;

  // What the front end knows about a finished name; the back end turns it
  // into the match flag.
  typedef struct packed {
    logic len_zero;
    logic glob;
    logic pos_hit;
    logic found;
  } end_info_t;

  // Only ASCII capitals are folded.
  function automatic logic [CHAR_BITS-1:0] fold_lower(input logic [CHAR_BITS-1:0] ch);
    return (ch >= UPPER_A && ch <= UPPER_Z) ? ch + CASE_SHIFT : ch;
  endfunction

endpackage

`default_nettype wire

// ----- sv/name_filter_glob_match.sv -----
// Entry-name filter, top level. A character stream of entry names comes in;
// one word per finished name goes out with the entry's index and a match flag.
// Configuration: write match_mode, pattern_len and the six pattern words
// through cfg_we_i / cfg_index_i / cfg_wdata_i while the block is idle.
// Input: one name character per word on valid/stall; last_char_i ends a name,
// empty_name_i ends it at once without using the character.
// Throughput: one character per cycle while in_stall_o is low. The position
// vector is updated by a compare row and one carry chain for the star runs.
// out_valid_o for a name rises once its end word has passed through the queue
// and into the result register. After every configuration write in_stall_o is
// high for one cycle while the star closure of the kept vector is rebuilt.
// When out_stall_i is high the result holds; a two-word queue and the result
// register keep taking characters until three results wait, then in_stall_o
// rises.
// Reset: empty pattern in plain mode, entry counter zero, no result pending.
// Depends on nfgm_pkg, nfgm_front, nfgm_fifo and nfgm_back.
`default_nettype none

module name_filter_glob_match #(
  parameter int unsigned MAX_PATTERN = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nfgm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nfgm_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [nfgm_pkg::CHAR_BITS-1:0]    name_char_i,
  input  logic                              last_char_i,
  input  logic                              empty_name_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nfgm_pkg::ENTRY_W-1:0]      entry_index_o,
  output logic                              matched_o
);
  import nfgm_pkg::*;

  logic      push;
  end_info_t push_data;
  logic      full;
  logic      fifo_valid;
  end_info_t fifo_data;
  logic      pop;

  nfgm_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_char_i  (name_char_i),
    .last_char_i  (last_char_i),
    .empty_name_i (empty_name_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  nfgm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (fifo_valid),
    .data_o      (fifo_data),
    .pop_i       (pop)
  );

  nfgm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_valid_i  (fifo_valid),
    .fifo_data_i   (fifo_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_index_o (entry_index_o),
    .matched_o     (matched_o)
  );

endmodule

`default_nettype wire

// ----- sv/nfgm_fifo.sv -----
// Two-word queue between the matcher front end and the result back end.
// Depends on nfgm_pkg for the word type.
`default_nettype none

module nfgm_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  nfgm_pkg::end_info_t   push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output nfgm_pkg::end_info_t   data_o,
  input  logic                  pop_i
);
  import nfgm_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  end_info_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/nfgm_front.sv -----
// Front end of the entry-name filter: configuration registers, case folding
// and the bit-parallel position vector. Depends on nfgm_pkg.
`default_nettype none

module nfgm_front #(
  parameter int unsigned MAX_PATTERN = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nfgm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nfgm_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [nfgm_pkg::CHAR_BITS-1:0]    name_char_i,
  input  logic                              last_char_i,
  input  logic                              empty_name_i,
  output logic                              push_o,
  output nfgm_pkg::end_info_t               push_data_o,
  input  logic                              full_i
);
  import nfgm_pkg::*;

  localparam int unsigned POS_W = MAX_PATTERN + 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  // A star at position i lets the match skip to i+1, and runs of stars chain.
  // That chain is a carry chain: stars propagate and active stars generate.
  function automatic logic [POS_W-1:0] close_run(input logic [POS_W-1:0] vec,
                                                 input logic [POS_W-1:0] stars);
    logic [POS_W-1:0] gen;
    logic [POS_W-1:0] carry;
    gen   = vec & stars;
    carry = (stars + gen) ^ stars ^ gen;
    return vec | carry;
  endfunction

  logic                   glob_q;
  logic [LEN_FIELD_W-1:0] plen_q;
  logic [CFG_W-1:0]       pat_words_q [PAT_WORDS];
  logic                   dirty_q;
  logic [POS_W-1:0]       state_q;
  logic [POS_W-1:0]       closed_q;
  logic [POS_W-1:0]       start_q;
  logic                   found_q;

  logic [LEN_W-1:0]       len;
  logic [CHAR_BITS-1:0]   ch;
  logic [MAX_PATTERN-1:0] eq_m;
  logic [MAX_PATTERN-1:0] star_m;
  logic [MAX_PATTERN-1:0] qm_m;
  logic [POS_W-1:0]       star_pos;
  logic [POS_W-1:0]       cur;
  logic [MAX_PATTERN-1:0] fwd;
  logic [MAX_PATTERN-1:0] stay;
  logic [POS_W-1:0]       nv;
  logic [POS_W-1:0]       adv;
  logic                   found_new;
  logic                   accept;
  logic                   ends;
  logic                   reclose;

  assign len = (plen_q > LEN_FIELD_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                    : plen_q[LEN_W-1:0];
  assign ch  = fold_lower(name_char_i);

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    localparam int unsigned WORD  = i / 4;
    localparam int unsigned SHIFT = (i % 4) * PACK_BITS;
    logic [CHAR_BITS-1:0] pc;
    logic                 in_len;
    assign pc        = pat_words_q[WORD][SHIFT +: PACK_BITS];
    assign in_len    = (LEN_W'(i) < len);
    assign eq_m[i]   = in_len && (pc == ch);
    assign star_m[i] = in_len && (pc == STAR_CHAR);
    assign qm_m[i]   = in_len && (pc == QMARK_CHAR);
  end

  assign star_pos = {1'b0, star_m};

  // In wildcard mode the kept vector is read after closing it over stars.
  assign cur  = glob_q ? closed_q : state_q;
  assign fwd  = cur[MAX_PATTERN-1:0] & (eq_m | (qm_m & {MAX_PATTERN{glob_q}}));
  assign stay = cur[MAX_PATTERN-1:0] & star_m & {MAX_PATTERN{glob_q}};
  assign nv   = {fwd, 1'b0} | {1'b0, stay};
  assign adv  = glob_q ? close_run(nv, star_pos) : (nv | POS_W'(1));

  assign found_new = found_q | (!glob_q && adv[len] && (len != '0));

  // After a configuration write the input stalls while the closed vector is rebuilt.
  assign in_stall_o = dirty_q | full_i;
  assign accept     = in_valid_i & !in_stall_o;
  assign ends       = last_char_i | empty_name_i;
  assign reclose    = dirty_q & !cfg_we_i;
  assign push_o     = accept & ends;

  always_comb begin
    push_data_o.len_zero = (len == '0);
    push_data_o.glob     = glob_q;
    push_data_o.pos_hit  = empty_name_i ? closed_q[len] : adv[len];
    push_data_o.found    = empty_name_i ? found_q : found_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glob_q   <= 1'b0;
      plen_q   <= '0;
      for (int k = 0; k < PAT_WORDS; k++) begin
        pat_words_q[k] <= '0;
      end
      dirty_q  <= 1'b0;
      state_q  <= POS_W'(1);
      closed_q <= POS_W'(1);
      start_q  <= POS_W'(1);
      found_q  <= 1'b0;
    end else begin
      dirty_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MATCH_MODE:  glob_q <= cfg_wdata_i[0];
          REG_PATTERN_LEN: plen_q <= cfg_wdata_i[LEN_FIELD_W-1:0];
          REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C,
          REG_PATTERN_D, REG_PATTERN_E, REG_PATTERN_F: begin
            pat_words_q[cfg_index_i - CFG_IDX_W'(REG_PATTERN_A)] <= cfg_wdata_i;
          end
          default: ;
        endcase
      end
      if (reclose) begin
        closed_q <= glob_q ? close_run(state_q, star_pos) : state_q;
        start_q  <= glob_q ? close_run(POS_W'(1), star_pos) : POS_W'(1);
      end else if (accept) begin
        if (ends) begin
          state_q  <= POS_W'(1);
          closed_q <= start_q;
          found_q  <= 1'b0;
        end else begin
          state_q  <= adv;
          closed_q <= adv;
          found_q  <= found_new;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/nfgm_back.sv -----
// Back end of the entry-name filter: entry counter and result register.
// Depends on nfgm_pkg for the queue word type.
`default_nettype none

module nfgm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fifo_valid_i,
  input  nfgm_pkg::end_info_t            fifo_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nfgm_pkg::ENTRY_W-1:0]   entry_index_o,
  output logic                           matched_o
);
  import nfgm_pkg::*;

  logic [ENTRY_W-1:0] counter_q;
  logic               out_valid_q;
  logic [ENTRY_W-1:0] index_q;
  logic               matched_q;
  logic               hit;

  assign hit = fifo_data_i.len_zero |
               (fifo_data_i.glob ? fifo_data_i.pos_hit : fifo_data_i.found);

  assign pop_o         = fifo_valid_i & (!out_valid_q | !out_stall_i);
  assign out_valid_o   = out_valid_q;
  assign entry_index_o = index_q;
  assign matched_o     = matched_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      index_q   <= counter_q;
      matched_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        counter_q   <= counter_q + ENTRY_W'(1);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/nfgm_checker.sv -----
// Port-level checks of the entry-name filter, bound to the top level.
// Depends on name_filter_glob_match_macros.svh.
`default_nettype none

`include "name_filter_glob_match_macros.svh"

module nfgm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_char_i,
  input logic        empty_name_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] entry_index_o,
  input logic        matched_o
);

  logic [2:0]  pend_q;
  logic [31:0] last_index_q;
  logic        seen_q;
  logic        in_end;
  logic        out_acc;

  assign in_end  = in_valid_i & !in_stall_o & (last_char_i | empty_name_i);
  assign out_acc = out_valid_o & !out_stall_i;

  // Names ended at the input but not yet delivered at the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_index_q <= '0;
      seen_q       <= 1'b0;
    end else begin
      pend_q <= pend_q + {2'b00, in_end} - {2'b00, out_acc};
      if (out_acc) begin
        last_index_q <= entry_index_o;
        seen_q       <= 1'b1;
      end
    end
  end

  `NFGM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(entry_index_o) && $stable(matched_o), "result word changed while stalled")
  `NFGM_ASSERT(a_index_step, (out_acc && seen_q) |-> (entry_index_o == last_index_q + 32'd1), "entry index did not step by one")
  `NFGM_ASSERT_NEXT(a_cfg_stall, cfg_we_i, in_stall_o, "input taken in the cycle after a configuration write")
  `NFGM_ASSERT(a_no_invented, out_valid_o |-> (pend_q != 3'd0), "result shown with no finished name pending")
  `NFGM_ASSERT(a_bounded, pend_q <= 3'd3, "more finished names held than the buffering allows")

endmodule

bind name_filter_glob_match nfgm_checker u_nfgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_char_i   (last_char_i),
  .empty_name_i  (empty_name_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .entry_index_o (entry_index_o),
  .matched_o     (matched_o)
);

`default_nettype wire
